// File: hdl/gcd_lcm_unit_defines.svh
// ----------------------------------------------------------------------------
// gcd_lcm_unit assertion macros
// Shared concurrent assertion helpers for the GCD/LCM unit.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define GLU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd_lcm_unit: assertion failed");
// next-cycle implication
`define GLU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd_lcm_unit: assertion failed");
`else
`define GLU_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define GLU_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/gcdlcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdlcm_pkg
// Fixed widths, operation and status codes, and inter-module structs.
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

    localparam int OPERAND_PORT_WIDTH = 32;
    localparam int RESULT_WIDTH       = 64;

    // operation select
    localparam logic OP_GCD = 1'b0;
    localparam logic OP_LCM = 1'b1;

    // result status
    localparam logic STATUS_OK           = 1'b0;
    localparam logic STATUS_ZERO_OPERAND = 1'b1;

    // divider command from the sequencer
    typedef struct packed {
        logic go;    // load operands and start
        logic wide;  // double-width dividend
    } div_ctl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic run;   // iterating
        logic done;  // quotient/remainder valid this cycle
    } div_sts_t;

    // finished result marker from the sequencer
    typedef struct packed {
        logic valid;
        logic status;
    } fin_t;

endpackage

// File: hdl/gcd_lcm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Signed GCD (Euclid, truncating remainder) or LCM (product / GCD) of two
// operands, using one shared iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Handshake         Payload
// command   start / busy      operation, operand_a, operand_b
// result    done (strobe)     result_value, status
//
// A command transfers at a clock edge with start high and busy low.
// Each Euclid remainder step is a W-step division in the shared divider
// (one quotient bit per cycle); GCD takes up to about 46 such steps at
// 32 bits. LCM adds a multiply step and a 2*W-step division. LCM with a
// zero operand answers the cycle after the transfer. rst_n clears control
// asynchronously.
// done is high one cycle per result; the receiver cannot hold it off.
// ----------------------------------------------------------------------------
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    output logic                                          busy,
    input  logic                                          operation,
    input  logic signed [gcdlcm_pkg::OPERAND_PORT_WIDTH-1:0] operand_a,
    input  logic signed [gcdlcm_pkg::OPERAND_PORT_WIDTH-1:0] operand_b,
    output logic                                          done,
    output logic signed [gcdlcm_pkg::RESULT_WIDTH-1:0]    result_value,
    output logic                                          status
);
    import gcdlcm_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic                    accept;
    logic [W-1:0]            a_low, b_low;
    logic [W-1:0]            a_mag, b_mag;
    logic                    a_neg, b_neg;
    logic                    seq_busy;
    div_ctl_t                div_ctl;
    div_sts_t                div_sts;
    logic [2*W-1:0]          div_dividend;
    logic [W-1:0]            div_divisor;
    logic [2*W-1:0]          div_quot;
    logic [W-1:0]            div_rem;
    fin_t                    fin;
    logic [RESULT_WIDTH-1:0] fin_value;
    logic                    done_reg;
    logic [RESULT_WIDTH-1:0] result_reg;
    logic                    status_reg;

    assign accept = start && !seq_busy;

    // operand take: low W bits as signed, split into sign and magnitude
    always_comb
    begin
        a_low = operand_a[W-1:0];
        b_low = operand_b[W-1:0];
        a_neg = a_low[W-1];
        b_neg = b_low[W-1];
        a_mag = a_neg ? W'(~a_low + W'(1)) : a_low;
        b_mag = b_neg ? W'(~b_low + W'(1)) : b_low;
    end

    gcdlcm_seq #(
        .W (W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (operation),
        .a_mag        (a_mag),
        .a_neg        (a_neg),
        .b_mag        (b_mag),
        .b_neg        (b_neg),
        .busy         (seq_busy),
        .div_ctl      (div_ctl),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_sts      (div_sts),
        .div_quot     (div_quot),
        .div_rem      (div_rem),
        .fin          (fin),
        .fin_value    (fin_value)
    );

    gcdlcm_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .sts       (div_sts),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            result_reg <= fin_value;
            status_reg <= fin.status;
        end
    end

    assign busy         = seq_busy;
    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

    // checks
    `GLU_ASSERT_IMP(a_done_has_cause, clk, rst_n, done, $past(seq_busy || start))
    `GLU_ASSERT_IMP(a_err_zero_value, clk, rst_n, done && status, result_reg == '0)
    `GLU_ASSERT_NXT(a_accept_progress, clk, rst_n, accept, seq_busy || done_reg)
    `GLU_ASSERT_IMP(a_div_go_idle, clk, rst_n, div_ctl.go, !div_sts.run)

endmodule

// File: hdl/gcdlcm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdlcm_div
// Shared unsigned restoring divider, one quotient bit per cycle. Runs W
// steps for a single-width dividend or 2W steps for a double-width one.
// ----------------------------------------------------------------------------
module gcdlcm_div #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gcdlcm_pkg::div_ctl_t  ctl,
    input  logic [2*W-1:0]        dividend,
    input  logic [W-1:0]          divisor,
    output gcdlcm_pkg::div_sts_t  sts,
    output logic [2*W-1:0]        quotient,
    output logic [W-1:0]          remainder
);
    import gcdlcm_pkg::*;

    localparam int CW = $clog2(2 * W + 1);

    logic [W-1:0]   rem_reg;
    logic [2*W-1:0] dq_reg;
    logic [W-1:0]   dsr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           run_reg;
    logic           done_reg;

    logic [W:0]     shifted;
    logic [W:0]     trial;
    logic           ge;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, dq_reg[2*W-1]};
        trial   = shifted - {1'b0, dsr_reg};
        ge      = !trial[W];
    end

    // control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= ctl.wide ? CW'(2 * W) : CW'(W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: partial remainder and dividend/quotient shifter
    always_ff @(posedge clk)
    begin
        if (ctl.go)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            dq_reg  <= ctl.wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? trial[W-1:0] : shifted[W-1:0];
            dq_reg  <= {dq_reg[2*W-2:0], ge};
        end
    end

    assign sts.run   = run_reg;
    assign sts.done  = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/gcdlcm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdlcm_seq
// Sequencer: Euclid loop on magnitudes with sign tracking, product for the
// LCM, and the final product/GCD division; the divisions use the shared divider.
// ----------------------------------------------------------------------------
module gcdlcm_seq #(
    parameter int W = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              op,
    input  logic [W-1:0]                      a_mag,
    input  logic                              a_neg,
    input  logic [W-1:0]                      b_mag,
    input  logic                              b_neg,
    output logic                              busy,
    output gcdlcm_pkg::div_ctl_t              div_ctl,
    output logic [2*W-1:0]                    div_dividend,
    output logic [W-1:0]                      div_divisor,
    input  gcdlcm_pkg::div_sts_t              div_sts,
    input  logic [2*W-1:0]                    div_quot,
    input  logic [W-1:0]                      div_rem,
    output gcdlcm_pkg::fin_t                  fin,
    output logic [gcdlcm_pkg::RESULT_WIDTH-1:0] fin_value
);
    import gcdlcm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TEST  = 6'b000010,
        S_WAIT  = 6'b000100,
        S_MULT  = 6'b001000,
        S_LDIV  = 6'b010000,
        S_LWAIT = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic           op_reg;
    logic [W-1:0]   x_reg, y_reg;
    logic           sx_reg, sy_reg;
    logic [W-1:0]   am_reg, bm_reg;
    logic           sab_reg;
    logic [2*W-1:0] prod_reg;
    logic           zero_in;

    assign zero_in = (a_mag == '0) || (b_mag == '0);

    // next state, divider command and result
    always_comb
    begin
        state_next   = state_reg;
        div_ctl.go   = 1'b0;
        div_ctl.wide = 1'b0;
        fin.valid    = 1'b0;
        fin.status   = STATUS_OK;
        fin_value    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_LCM && zero_in)
                    begin
                        fin.valid  = 1'b1;
                        fin.status = STATUS_ZERO_OPERAND;
                    end
                    else
                    begin
                        state_next = S_TEST;
                    end
                end
            end
            S_TEST:
            begin
                if (y_reg == '0)
                begin
                    if (op_reg == OP_GCD)
                    begin
                        fin.valid  = 1'b1;
                        fin_value  = sx_reg ? -RESULT_WIDTH'(x_reg) : RESULT_WIDTH'(x_reg);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MULT;
                    end
                end
                else
                begin
                    div_ctl.go = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = S_TEST;
                end
            end
            S_MULT:
            begin
                state_next = S_LDIV;
            end
            S_LDIV:
            begin
                div_ctl.go   = 1'b1;
                div_ctl.wide = 1'b1;
                state_next   = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (div_sts.done)
                begin
                    fin.valid  = 1'b1;
                    fin_value  = (sab_reg ^ sx_reg) ? -RESULT_WIDTH'(div_quot)
                                                    : RESULT_WIDTH'(div_quot);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // divider operands: remainder step or product over GCD
    assign div_dividend = (state_reg == S_LDIV) ? prod_reg : (2 * W)'(x_reg);
    assign div_divisor  = (state_reg == S_LDIV) ? x_reg : y_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Euclid registers, product
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            op_reg  <= op;
            x_reg   <= a_mag;
            y_reg   <= b_mag;
            sx_reg  <= a_neg;
            sy_reg  <= b_neg;
            am_reg  <= a_mag;
            bm_reg  <= b_mag;
            sab_reg <= a_neg ^ b_neg;
        end
        else if (state_reg == S_WAIT && div_sts.done)
        begin
            // truncating remainder: sign of dividend rides with the remainder into y
            x_reg  <= y_reg;
            y_reg  <= div_rem;
            sx_reg <= sy_reg;
            sy_reg <= sx_reg;
        end
        if (state_reg == S_MULT)
        begin
            prod_reg <= (2 * W)'(am_reg) * (2 * W)'(bm_reg);
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: tb/sv/gcd_lcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_checker
// Watches the command and result channels of gcd_lcm_unit, predicts the GCD
// or LCM of every command that transfers, and compares each result strobe
// field by field against the oldest pending answer.
// ----------------------------------------------------------------------------
module gcd_lcm_checker #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             start,
    input  logic                                             busy,
    input  logic                                             operation,
    input  logic signed [gcdlcm_pkg::OPERAND_PORT_WIDTH-1:0] operand_a,
    input  logic signed [gcdlcm_pkg::OPERAND_PORT_WIDTH-1:0] operand_b,
    input  logic                                             done,
    input  logic signed [gcdlcm_pkg::RESULT_WIDTH-1:0]       result_value,
    input  logic                                             status,
    output int                                               mismatch_count,
    output int                                               pending_results
);
    import gcdlcm_pkg::*;

    // one predicted answer, with the command that produced it for debug
    typedef struct {
        logic                          op;
        logic [OPERAND_PORT_WIDTH-1:0] a_raw;
        logic [OPERAND_PORT_WIDTH-1:0] b_raw;
        logic signed [RESULT_WIDTH-1:0] value;
        logic                          status;
    } gcd_answer_t;

    gcd_answer_t answer_queue[$];
    int          fail_total = 0;
    int          backlog    = 0;

    assign mismatch_count  = fail_total;
    assign pending_results = backlog;

    // low OPERAND_WIDTH bits, sign-extended to 64 bits
    function automatic longint widen_operand(input logic [OPERAND_PORT_WIDTH-1:0] raw);
        longint v;
        v = longint'(raw);
        v = v <<< (64 - OPERAND_WIDTH);
        v = v >>> (64 - OPERAND_WIDTH);
        return v;
    endfunction

    // Euclid with truncating remainder; sign follows the operands
    function automatic longint euclid_gcd(input longint x, input longint y);
        longint r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic gcd_answer_t predict_answer(
        input logic                          op,
        input logic [OPERAND_PORT_WIDTH-1:0] a_raw,
        input logic [OPERAND_PORT_WIDTH-1:0] b_raw
    );
        gcd_answer_t ans;
        longint      a;
        longint      b;
        a         = widen_operand(a_raw);
        b         = widen_operand(b_raw);
        ans.op    = op;
        ans.a_raw = a_raw;
        ans.b_raw = b_raw;
        ans.value  = '0;
        ans.status = STATUS_OK;
        if (op == OP_GCD)
            ans.value = euclid_gcd(a, b);
        else if (a == 0 || b == 0)
            ans.status = STATUS_ZERO_OPERAND;
        else
            ans.value = (a * b) / euclid_gcd(a, b);   // exact, |a*b| <= 2^62
        return ans;
    endfunction

    task automatic flag_mismatch(input string what, input gcd_answer_t want);
        if (fail_total < 10)
            $display("[%0t] gcd_lcm %s: op %0d a %0d b %0d expected value %0d status %0d, got value %0d status %0d",
                     $time, what, want.op, $signed(want.a_raw), $signed(want.b_raw),
                     want.value, want.status, result_value, status);
        fail_total++;
    endtask

    // result check first, so a strobe is never matched to a same-edge command
    always @(posedge clk or negedge rst_n)
    begin : channel_watch
        gcd_answer_t want;
        if (!rst_n)
        begin
            answer_queue.delete();
            backlog <= 0;
        end
        else
        begin
            if (done)
            begin
                if (answer_queue.size() == 0)
                begin
                    want = '{default: '0};
                    flag_mismatch("result with no command pending", want);
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (result_value !== want.value && status !== want.status)
                        flag_mismatch("value and status mismatch", want);
                    else if (result_value !== want.value)
                        flag_mismatch("value mismatch", want);
                    else if (status !== want.status)
                        flag_mismatch("status mismatch", want);
                end
            end
            if (start && !busy)
                answer_queue.push_back(predict_answer(operation, operand_a, operand_b));
            backlog <= answer_queue.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives gcd_lcm_unit with directed corner commands (zero operands, most
// negative values, worst-case Euclid chains, signed LCMs) and then a mix of
// random, small, shared-factor and boundary operands, with random sender
// gaps and drain pauses. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_top;
    import gcdlcm_pkg::*;

    localparam int OPERAND_WIDTH = 32;
    localparam int RANDOM_ITEMS  = 350;
    localparam int QUIET_TAIL    = 60;      // final commands sent back to back
    localparam int STALL_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 1800;

    localparam logic [OPERAND_PORT_WIDTH-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [OPERAND_PORT_WIDTH-1:0] MOST_POS = 32'h7fff_ffff;
    localparam logic [OPERAND_PORT_WIDTH-1:0] MINUS_1  = 32'hffff_ffff;
    localparam logic [OPERAND_PORT_WIDTH-1:0] FIB_46   = 32'd1836311903;
    localparam logic [OPERAND_PORT_WIDTH-1:0] FIB_45   = 32'd1134903170;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic                                   operation;
    logic signed [OPERAND_PORT_WIDTH-1:0]   operand_a;
    logic signed [OPERAND_PORT_WIDTH-1:0]   operand_b;
    logic                                   done;
    logic signed [RESULT_WIDTH-1:0]         result_value;
    logic                                   status;
    int                                     mismatch_count;
    int                                     pending_results;
    int                                     stall_cycles = 0;

    gcd_lcm_unit #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .done         (done),
        .result_value (result_value),
        .status       (status)
    );

    gcd_lcm_checker #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) CHECK (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .operand_a       (operand_a),
        .operand_b       (operand_b),
        .done            (done),
        .result_value    (result_value),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: cycles with neither a command transfer nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // hold the command until busy is low, then let it transfer
    task automatic send_command(
        input logic                          op,
        input logic [OPERAND_PORT_WIDTH-1:0] a,
        input logic [OPERAND_PORT_WIDTH-1:0] b
    );
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        #1;
        while (busy)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
    endtask

    // sender gap with noise on the payload
    task automatic idle_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start     <= 1'b0;
            operation <= 1'($urandom);
            operand_a <= $urandom;
            operand_b <= $urandom;
        end
    endtask

    // stop sending until every pending result has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    function automatic logic [OPERAND_PORT_WIDTH-1:0] boundary_operand();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'd1;
            2:       return MINUS_1;
            3:       return MOST_POS;
            4:       return MOST_NEG;
            default: return $urandom;
        endcase
    endfunction

    // operand mix: full range, small, shared factor, boundary
    task automatic pick_operands(
        output logic [OPERAND_PORT_WIDTH-1:0] a,
        output logic [OPERAND_PORT_WIDTH-1:0] b
    );
        int unsigned kind;
        int unsigned factor;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (kind < 6)
        begin
            a = $urandom_range(0, 600) - 300;
            b = $urandom_range(0, 600) - 300;
        end
        else if (kind < 9)
        begin
            // product stays below 2^31
            factor = $urandom_range(1, 65535);
            a = factor * $urandom_range(1, 32767);
            b = factor * $urandom_range(1, 32767);
            if ($urandom_range(0, 1))
                a = -a;
            if ($urandom_range(0, 1))
                b = -b;
        end
        else
        begin
            a = boundary_operand();
            b = boundary_operand();
        end
    endtask

    initial
    begin : stimulus
        logic [OPERAND_PORT_WIDTH-1:0] a;
        logic [OPERAND_PORT_WIDTH-1:0] b;
        logic                          op;

        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_GCD;
        operand_a = '0;
        operand_b = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners
        send_command(OP_GCD, '0, '0);
        send_command(OP_GCD, MOST_NEG, '0);
        send_command(OP_GCD, '0, -32'sd7);
        send_command(OP_GCD, MOST_NEG, MINUS_1);
        send_command(OP_GCD, MOST_NEG, MOST_NEG);
        send_command(OP_GCD, MOST_POS, MOST_POS);
        send_command(OP_GCD, MOST_POS, MOST_NEG);
        send_command(OP_GCD, FIB_46, FIB_45);
        send_command(OP_GCD, -32'sd12, 32'sd18);
        send_command(OP_GCD, 32'sd12, -32'sd18);
        send_command(OP_GCD, MINUS_1, 32'sd1);
        send_command(OP_LCM, '0, 32'sd5);
        send_command(OP_LCM, 32'sd5, '0);
        send_command(OP_LCM, '0, '0);
        send_command(OP_LCM, MOST_NEG, MOST_NEG);
        send_command(OP_LCM, MOST_POS, MOST_POS - 1);
        send_command(OP_LCM, MOST_NEG, MOST_POS);
        send_command(OP_LCM, -32'sd4, 32'sd6);
        send_command(OP_LCM, 32'sd4, -32'sd6);
        send_command(OP_LCM, FIB_46, FIB_45);
        send_command(OP_LCM, MINUS_1, MOST_NEG);
        send_command(OP_LCM, 32'sd1, 32'sd1);
        drain_results();

        // random commands; gaps and drains stop in the final stretch
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            op = $urandom_range(0, 1) ? OP_LCM : OP_GCD;
            pick_operands(a, b);
            send_command(op, a, b);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            else if (i < RANDOM_ITEMS - QUIET_TAIL)
            begin
                if ($urandom_range(0, 39) == 0)
                    drain_results();
                else if ($urandom_range(0, 2) == 0)
                    idle_gap($urandom_range(1, 8));
            end
        end

        // let everything come back, then watch for stray strobes
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
